FILE: src/i2cm_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
`default_nettype none

package i2cm_pkg;

  localparam int unsigned WAIT_BITS = 16;
  localparam int unsigned STEP_BITS = 3;
  localparam int unsigned BCNT_BITS = 4;

  localparam logic [WAIT_BITS-1:0] PHASE_TICKS_RST = WAIT_BITS'(120);
  localparam logic [BCNT_BITS-1:0] DATA_BITS = BCNT_BITS'(8);
  localparam logic [BCNT_BITS-1:0] RESET_PULSES = BCNT_BITS'(9);

  // Command codes as carried in the mode field.
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_STOP  = 3'd2;
  localparam logic [2:0] MODE_WRITE = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;
  localparam logic [2:0] MODE_RESET = 3'd5;

  typedef enum logic [5:0] {
    CMD_IDLE  = 6'b000001,
    CMD_START = 6'b000010,
    CMD_STOP  = 6'b000100,
    CMD_WRITE = 6'b001000,
    CMD_READ  = 6'b010000,
    CMD_RESET = 6'b100000
  } cmd_state_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       ack_to_send;
    logic       sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive_level;
    logic       sda_released;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
  } out_word_t;

endpackage

`default_nettype wire

FILE: src/i2c_master_bit_sequencer.sv
// An accepted word's result is registered in the output register, or in the skid
// entry while out_ stalls. One word per cycle while in_stall is low; each word is
// one bus tick and the sequencer step is a single registered pass. in_stall rises
// only when the result register and its skid entry both hold words not yet taken.
// Reset (rst_n low, synchronous): bus idle, SCL and SDA high and driven,
// phase length 120 ticks, result channel empty.
`default_nettype none

module i2c_master_bit_sequencer import i2cm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // tick / command channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_word_t             in_word,
  // per-tick result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_word_t                 out_word,
  // phase length register
  input  wire logic                 cfg_wr_en,
  input  wire logic [WAIT_BITS-1:0] cfg_wr_data
);

  logic      accept;
  logic      skid_full;
  out_word_t res_word;

  // The sequencer advances exactly once per accepted word.
  assign accept   = in_valid && !skid_full;
  assign in_stall = skid_full;

  // Pin sequencing: command decode, phase timer, bit/shift handling.
  i2cm_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (accept),
    .in_word     (in_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res_word    (res_word)
  );

  // Output register plus skid entry so a stalled consumer costs no tick.
  i2cm_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_word (res_word),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // A full skid entry implies the result register is also occupied.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("skid entry occupied with empty result register");

  // Completion word always reports the bus idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.done_res) |-> !out_word.busy_res)
    else $error("done reported while still busy");

  // Every command hands SDA back to the driver before going idle.
  a_idle_sda_driven: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.busy_res) |-> !out_word.sda_released)
    else $error("SDA left released while idle");

  // An accepted word always leaves out_valid high on the next cycle.
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted word produced no result");

endmodule

`default_nettype wire

FILE: src/i2cm_core.sv
// Bus sequencer state and the per-tick next-state / result logic.
`default_nettype none

module i2cm_core import i2cm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step_en,
  input  wire in_word_t             in_word,
  input  wire logic                 cfg_wr_en,
  input  wire logic [WAIT_BITS-1:0] cfg_wr_data,
  output out_word_t                 res_word
);

  cmd_state_t           cmd_r, cmd_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;
  logic [BCNT_BITS-1:0] bcnt_r, bcnt_nxt;
  logic [7:0]           shift_r, shift_nxt;
  logic [WAIT_BITS-1:0] wait_r, wait_nxt;
  logic                 scl_r, scl_nxt;
  logic                 sda_r, sda_nxt;
  logic                 rel_r, rel_nxt;
  logic                 ack_r, ack_nxt;
  logic [7:0]           rx_r, rx_nxt;
  logic                 ackd_r, ackd_nxt;
  logic [WAIT_BITS-1:0] phase_r;
  logic [WAIT_BITS-1:0] wait_load;
  logic                 done;
  logic                 do_enter;
  logic                 fin;

  // Zero phase length behaves like one.
  assign wait_load = (phase_r == '0) ? '0 : phase_r - WAIT_BITS'(1);

  always_comb begin
    cmd_nxt   = cmd_r;
    step_nxt  = step_r;
    bcnt_nxt  = bcnt_r;
    shift_nxt = shift_r;
    wait_nxt  = wait_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    rel_nxt   = rel_r;
    ack_nxt   = ack_r;
    rx_nxt    = rx_r;
    ackd_nxt  = ackd_r;
    done      = 1'b0;
    do_enter  = 1'b0;
    fin       = 1'b0;

    if (cmd_r == CMD_IDLE) begin
      do_enter  = 1'b1;
      step_nxt  = '0;
      bcnt_nxt  = '0;
      shift_nxt = '0;
      case (in_word.mode)
        MODE_START: cmd_nxt = CMD_START;
        MODE_STOP:  cmd_nxt = CMD_STOP;
        MODE_WRITE: begin
          cmd_nxt   = CMD_WRITE;
          shift_nxt = in_word.tx_byte;
        end
        MODE_READ: begin
          cmd_nxt  = CMD_READ;
          ackd_nxt = in_word.ack_to_send;
        end
        MODE_RESET: cmd_nxt = CMD_RESET;
        default: begin
          do_enter  = 1'b0;
          step_nxt  = step_r;
          bcnt_nxt  = bcnt_r;
          shift_nxt = shift_r;
        end
      endcase
    end else if (wait_r != '0) begin
      wait_nxt = wait_r - WAIT_BITS'(1);
    end else begin
      // End of the current phase.
      step_nxt = step_r + STEP_BITS'(1);
      case (cmd_r)
        CMD_START: fin = (step_r >= STEP_BITS'(2));
        CMD_STOP:  fin = (step_r >= STEP_BITS'(1));
        CMD_WRITE: begin
          if (step_r == STEP_BITS'(2)) begin
            shift_nxt = {shift_r[6:0], 1'b0};
            bcnt_nxt  = bcnt_r + BCNT_BITS'(1);
            step_nxt  = (bcnt_nxt < DATA_BITS) ? STEP_BITS'(0) : STEP_BITS'(3);
          end
          if (step_r == STEP_BITS'(4)) ack_nxt = in_word.sda_in;
          if (step_r >= STEP_BITS'(5)) begin
            rel_nxt = 1'b0;
            fin     = 1'b1;
          end
        end
        CMD_READ: begin
          if (step_r == STEP_BITS'(1)) shift_nxt = {shift_r[6:0], in_word.sda_in};
          if (step_r == STEP_BITS'(2)) begin
            bcnt_nxt = bcnt_r + BCNT_BITS'(1);
            step_nxt = (bcnt_nxt < DATA_BITS) ? STEP_BITS'(0) : STEP_BITS'(3);
          end
          if (step_r >= STEP_BITS'(5)) begin
            rx_nxt = shift_r;
            fin    = 1'b1;
          end
        end
        default: begin
          if (step_r == STEP_BITS'(2)) begin
            bcnt_nxt = bcnt_r + BCNT_BITS'(1);
            step_nxt = (bcnt_nxt < RESET_PULSES) ? STEP_BITS'(1) : STEP_BITS'(3);
          end
          fin = (step_r >= STEP_BITS'(4));
        end
      endcase
      if (fin) begin
        cmd_nxt  = CMD_IDLE;
        step_nxt = '0;
        bcnt_nxt = '0;
        done     = 1'b1;
      end else begin
        do_enter = 1'b1;
      end
    end

    // Pin levels of the phase being entered.
    if (do_enter) begin
      wait_nxt = wait_load;
      case (cmd_nxt)
        CMD_START: begin
          if (step_nxt == STEP_BITS'(0)) begin
            scl_nxt = 1'b1;
            sda_nxt = 1'b1;
            rel_nxt = 1'b0;
          end else if (step_nxt == STEP_BITS'(1)) begin
            sda_nxt = 1'b0;
          end else begin
            scl_nxt = 1'b0;
          end
        end
        CMD_STOP: begin
          if (step_nxt == STEP_BITS'(0)) begin
            scl_nxt = 1'b1;
            sda_nxt = 1'b0;
            rel_nxt = 1'b0;
          end else begin
            sda_nxt = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (step_nxt == STEP_BITS'(0)) begin
            sda_nxt = shift_nxt[7];
          end else if (step_nxt == STEP_BITS'(1) || step_nxt == STEP_BITS'(4)) begin
            scl_nxt = 1'b1;
          end else if (step_nxt == STEP_BITS'(2) || step_nxt == STEP_BITS'(5)) begin
            scl_nxt = 1'b0;
          end else begin
            sda_nxt = 1'b1;
            rel_nxt = 1'b1;
          end
        end
        CMD_READ: begin
          if (step_nxt == STEP_BITS'(0)) begin
            scl_nxt = 1'b0;
            rel_nxt = 1'b1;
          end else if (step_nxt == STEP_BITS'(1) || step_nxt == STEP_BITS'(4)) begin
            scl_nxt = 1'b1;
          end else if (step_nxt == STEP_BITS'(2) || step_nxt == STEP_BITS'(5)) begin
            scl_nxt = 1'b0;
          end else begin
            sda_nxt = ackd_nxt;
            rel_nxt = 1'b0;
          end
        end
        default: begin
          if (step_nxt == STEP_BITS'(0)) begin
            scl_nxt = 1'b1;
            sda_nxt = 1'b1;
            rel_nxt = 1'b0;
          end else if (step_nxt == STEP_BITS'(1)) begin
            scl_nxt = 1'b0;
          end else if (step_nxt == STEP_BITS'(2)) begin
            scl_nxt = 1'b1;
          end else if (step_nxt == STEP_BITS'(3)) begin
            scl_nxt = 1'b1;
            sda_nxt = 1'b0;
            rel_nxt = 1'b0;
          end else begin
            sda_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    res_word.scl_level       = scl_nxt;
    res_word.sda_drive_level = sda_nxt;
    res_word.sda_released    = rel_nxt;
    res_word.busy_res        = (cmd_nxt != CMD_IDLE);
    res_word.done_res        = done;
    res_word.rx_byte         = rx_nxt;
    res_word.ack_received    = ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_TICKS_RST;
    end else if (cfg_wr_en) begin
      phase_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= CMD_IDLE;
      step_r  <= '0;
      bcnt_r  <= '0;
      shift_r <= '0;
      wait_r  <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      rel_r   <= 1'b0;
      ack_r   <= 1'b0;
      rx_r    <= '0;
      ackd_r  <= 1'b0;
    end else if (step_en) begin
      cmd_r   <= cmd_nxt;
      step_r  <= step_nxt;
      bcnt_r  <= bcnt_nxt;
      shift_r <= shift_nxt;
      wait_r  <= wait_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      rel_r   <= rel_nxt;
      ack_r   <= ack_nxt;
      rx_r    <= rx_nxt;
      ackd_r  <= ackd_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/i2cm_skid.sv
// Result register with one skid entry on the output channel.
`default_nettype none

module i2cm_skid import i2cm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire out_word_t push_word,
  output logic           full,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_word_t out_word_r, out_word_nxt;
  out_word_t skid_word_r, skid_word_nxt;
  logic      pop;

  assign pop       = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_word_nxt   = out_word_r;
    skid_word_nxt  = skid_word_r;
    if (!out_valid_r || pop) begin
      out_valid_nxt  = skid_valid_r || push;
      out_word_nxt   = skid_valid_r ? skid_word_r : push_word;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_word_nxt  = push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the I2C master bit sequencer: directed commands plus random traffic.
`default_nettype none

module tb_top;
  import i2cm_pkg::*;

  // Mode codes the block must treat as a plain tick.
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  // What to put in the mode field while a command is running.
  localparam int BUSY_TICKS_ONLY = 0;
  localparam int BUSY_ANY_MODE   = 1;
  localparam int BUSY_SAME_MODE  = 2;

  // Level offered on sda_in.
  localparam int SDA_LOW    = 0;
  localparam int SDA_HIGH   = 1;
  localparam int SDA_RANDOM = 2;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;
  logic                 cfg_wr_en = 1'b0;
  logic [WAIT_BITS-1:0] cfg_wr_data = '0;

  i2c_master_bit_sequencer uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Bus sequencer shadow. One call per accepted word, same order as the block.
  // cur_cmd holds MODE_TICK while no command is running.
  // ---------------------------------------------------------------------------
  logic [WAIT_BITS-1:0] phase_len = PHASE_TICKS_RST;
  logic [2:0]           cur_cmd = MODE_TICK;
  logic [4:0]           step = '0;
  logic [BCNT_BITS-1:0] bit_cnt = '0;
  logic [7:0]           shreg = '0;
  logic [WAIT_BITS-1:0] wait_cnt = '0;
  logic                 scl_q = 1'b1;
  logic                 sda_q = 1'b1;
  logic                 sda_rel = 1'b0;
  logic                 ack_q = 1'b0;
  logic [7:0]           rx_q = '0;
  logic                 nack_q = 1'b0;

  out_word_t            expected_pins[$];
  out_word_t            want_word;
  int unsigned          words_sent = 0;
  int unsigned          fail_count = 0;
  int unsigned          mismatch_count = 0;
  int unsigned          send_idle_pct = 0;
  int unsigned          stall_pct = 0;

  // Drive the pins of the phase being entered, then arm the phase timer.
  // A zero length behaves as one tick.
  task automatic begin_phase();
    case (cur_cmd)
      MODE_START: begin
        case (step)
          0: {scl_q, sda_q, sda_rel} = 3'b110;
          1: sda_q = 1'b0;
          default: scl_q = 1'b0;
        endcase
      end
      MODE_STOP: begin
        if (step == 0) {scl_q, sda_q, sda_rel} = 3'b100;
        else sda_q = 1'b1;
      end
      MODE_WRITE: begin
        if (step == 0) sda_q = shreg[7];
        else if (step == 1 || step == 4) scl_q = 1'b1;
        else if (step == 2 || step == 5) scl_q = 1'b0;
        else begin
          sda_q = 1'b1;
          sda_rel = 1'b1;
        end
      end
      MODE_READ: begin
        if (step == 0) begin
          scl_q = 1'b0;
          sda_rel = 1'b1;
        end else if (step == 1 || step == 4) scl_q = 1'b1;
        else if (step == 2 || step == 5) scl_q = 1'b0;
        else begin
          sda_q = nack_q;
          sda_rel = 1'b0;
        end
      end
      default: begin
        // bus reset: idle, a train of RESET_PULSES clock pulses on SCL, then a stop
        case (step)
          0: {scl_q, sda_q, sda_rel} = 3'b110;
          1: scl_q = 1'b0;
          2: scl_q = 1'b1;
          3: {scl_q, sda_q, sda_rel} = 3'b100;
          default: sda_q = 1'b1;
        endcase
      end
    endcase
    wait_cnt = (phase_len == '0) ? '0 : phase_len - 1'b1;
  endtask

  task automatic i2c_tick(input in_word_t w, output out_word_t r);
    logic done;
    logic jumped;
    done = 1'b0;
    jumped = 1'b0;
    if (cur_cmd == MODE_TICK) begin
      // idle: only a real command code starts a sequence
      if (w.mode >= MODE_START && w.mode <= MODE_RESET) begin
        cur_cmd = w.mode;
        step = '0;
        bit_cnt = '0;
        shreg = (w.mode == MODE_WRITE) ? w.tx_byte : 8'h00;
        if (w.mode == MODE_READ) nack_q = w.ack_to_send;
        begin_phase();
      end
    end else if (wait_cnt != '0) begin
      wait_cnt = wait_cnt - 1'b1;
    end else begin
      // phase ends on this tick; sampling phases take sda_in now
      case (cur_cmd)
        MODE_START: done = (step >= 2);
        MODE_STOP:  done = (step >= 1);
        MODE_WRITE: begin
          if (step == 2) begin
            shreg = shreg << 1;
            bit_cnt = bit_cnt + 1'b1;
            step = (bit_cnt < DATA_BITS) ? 5'd0 : 5'd3;
            jumped = 1'b1;
          end else begin
            if (step == 4) ack_q = w.sda_in;
            if (step >= 5) begin
              sda_rel = 1'b0;
              done = 1'b1;
            end
          end
        end
        MODE_READ: begin
          if (step == 1) shreg = {shreg[6:0], w.sda_in};
          if (step == 2) begin
            bit_cnt = bit_cnt + 1'b1;
            step = (bit_cnt < DATA_BITS) ? 5'd0 : 5'd3;
            jumped = 1'b1;
          end else if (step >= 5) begin
            rx_q = shreg;
            done = 1'b1;
          end
        end
        default: begin
          if (step == 2) begin
            bit_cnt = bit_cnt + 1'b1;
            step = (bit_cnt < RESET_PULSES) ? 5'd1 : 5'd3;
            jumped = 1'b1;
          end else done = (step >= 4);
        end
      endcase
      if (done) begin
        cur_cmd = MODE_TICK;
        step = '0;
        bit_cnt = '0;
      end else begin
        if (!jumped) step = step + 1'b1;
        begin_phase();
      end
    end
    r.scl_level       = scl_q;
    r.sda_drive_level = sda_q;
    r.sda_released    = sda_rel;
    r.busy_res        = (cur_cmd != MODE_TICK);
    r.done_res        = done;
    r.rx_byte         = rx_q;
    r.ack_received    = ack_q;
  endtask

  // ---------------------------------------------------------------------------
  // Word driver. Called and returns at a falling edge; in_valid stays high on
  // return so the caller must follow with another word or a drain.
  // ---------------------------------------------------------------------------
  task automatic send_word(input in_word_t w);
    out_word_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    i2c_tick(w, r);
    expected_pins.push_back(r);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_tick(input logic [2:0] m, input logic [7:0] tx, input logic ack,
                           input int sda_sel);
    in_word_t w;
    w.mode        = m;
    w.tx_byte     = tx;
    w.ack_to_send = ack;
    w.sda_in      = (sda_sel == SDA_RANDOM) ? 1'($urandom_range(1)) : (sda_sel == SDA_HIGH);
    send_word(w);
  endtask

  // Tick until the shadow says the running command is over. The mode field
  // while busy must be ignored, including on the completing tick.
  task automatic run_until_idle(input logic [2:0] cmd, input int busy_sel, input int sda_sel);
    logic [2:0] m;
    while (cur_cmd != MODE_TICK) begin
      case (busy_sel)
        BUSY_TICKS_ONLY: m = MODE_TICK;
        BUSY_ANY_MODE:   m = 3'($urandom_range(7));
        default:         m = cmd;
      endcase
      send_tick(m, 8'($urandom_range(255)), 1'($urandom_range(1)), sda_sel);
    end
  endtask

  task automatic run_command(input logic [2:0] cmd, input logic [7:0] tx, input logic ack,
                             input int busy_sel, input int sda_sel);
    send_tick(cmd, tx, ack, sda_sel);
    run_until_idle(cmd, busy_sel, sda_sel);
  endtask

  // Hold off the sender until every predicted word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_pins.size() != 0) @(negedge clk);
  endtask

  // Phase length writes happen only with the result channel empty.
  task automatic set_phase_len(input logic [WAIT_BITS-1:0] v);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    phase_len = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset phase length of 120 ticks, with light idling on both sides.
  task automatic test_reset_phase_len();
    send_idle_pct = 13;
    stall_pct = 13;
    run_command(MODE_STOP, 8'hFF, 1'b1, BUSY_ANY_MODE, SDA_RANDOM);
    drain_results();
  endtask

  // A zero phase length must behave as one tick.
  task automatic test_zero_phase_len();
    send_idle_pct = 0;
    stall_pct = 0;
    set_phase_len('0);
    run_command(MODE_START, 8'hA5, 1'b0, BUSY_TICKS_ONLY, SDA_RANDOM);
    run_command(MODE_WRITE, 8'h5A, 1'b0, BUSY_TICKS_ONLY, SDA_LOW);
    drain_results();
  endtask

  // Every command at least once at phase length 1, data extremes, ACK and NACK both
  // ways, spare mode codes while idle, commands offered while busy.
  task automatic test_each_command();
    send_idle_pct = 0;
    stall_pct = 0;
    set_phase_len(16'd1);
    send_tick(MODE_SPARE6, 8'hFF, 1'b1, SDA_HIGH);
    send_tick(MODE_SPARE7, 8'h00, 1'b0, SDA_LOW);
    send_tick(MODE_TICK, 8'hFF, 1'b1, SDA_HIGH);
    run_command(MODE_START, 8'h00, 1'b0, BUSY_TICKS_ONLY, SDA_LOW);
    // ACK from the slave, then NACK
    run_command(MODE_WRITE, 8'hFF, 1'b0, BUSY_TICKS_ONLY, SDA_LOW);
    run_command(MODE_WRITE, 8'h00, 1'b1, BUSY_ANY_MODE, SDA_HIGH);
    // all-ones byte answered with ACK, all-zeros with NACK
    run_command(MODE_READ, 8'h00, 1'b0, BUSY_TICKS_ONLY, SDA_HIGH);
    run_command(MODE_READ, 8'hFF, 1'b1, BUSY_ANY_MODE, SDA_LOW);
    run_command(MODE_READ, 8'h3C, 1'b0, BUSY_TICKS_ONLY, SDA_RANDOM);
    run_command(MODE_STOP, 8'h00, 1'b0, BUSY_TICKS_ONLY, SDA_RANDOM);
    // same command held on mode through the completing tick: it must be
    // taken only on the tick after, so two back-to-back resets result
    run_command(MODE_RESET, 8'h00, 1'b0, BUSY_SAME_MODE, SDA_RANDOM);
    run_command(MODE_RESET, 8'h00, 1'b0, BUSY_TICKS_ONLY, SDA_RANDOM);
    run_command(MODE_WRITE, 8'h81, 1'b0, BUSY_SAME_MODE, SDA_RANDOM);
    run_command(MODE_WRITE, 8'h81, 1'b0, BUSY_TICKS_ONLY, SDA_RANDOM);
    drain_results();
  endtask

  // A long phase length, then a length change in the middle of a command,
  // which must only apply from the next phase on.
  task automatic test_long_phase();
    send_idle_pct = 0;
    stall_pct = 0;
    set_phase_len(16'd20);
    send_tick(MODE_START, 8'h00, 1'b0, SDA_RANDOM);
    repeat (30) send_tick(MODE_TICK, 8'($urandom_range(255)), 1'b0, SDA_RANDOM);
    set_phase_len(16'd3);
    run_until_idle(MODE_TICK, BUSY_ANY_MODE, SDA_RANDOM);
    drain_results();
  endtask

  // Mostly whole commands with random content, some idle and spare-code
  // ticks, over the four idling profiles. Length writes land only between commands.
  task automatic test_random_traffic();
    int          profile;
    int unsigned stop_at;
    logic [2:0]  m;
    for (profile = 0; profile < 4; profile++) begin
      case (profile)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
      set_phase_len((profile == 0) ? 16'd1 : 16'($urandom_range(1, 3)));
      stop_at = words_sent + 25;
      while (words_sent < stop_at) begin
        if ($urandom_range(99) < 70) begin
          run_command(3'($urandom_range(MODE_START, MODE_RESET)), 8'($urandom_range(255)),
                      1'($urandom_range(1)), $urandom_range(BUSY_TICKS_ONLY, BUSY_SAME_MODE),
                      SDA_RANDOM);
        end else begin
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(2))
              0: m = MODE_TICK;
              1: m = MODE_SPARE6;
              default: m = MODE_SPARE7;
            endcase
            send_tick(m, 8'($urandom_range(255)), 1'($urandom_range(1)), SDA_RANDOM);
          end
        end
      end
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, compare each taken word with the oldest
  // prediction.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pins.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word %h", out_word);
      end else begin
        want_word = expected_pins.pop_front();
        if (out_word.scl_level !== want_word.scl_level ||
            out_word.sda_drive_level !== want_word.sda_drive_level ||
            out_word.sda_released !== want_word.sda_released ||
            out_word.busy_res !== want_word.busy_res ||
            out_word.done_res !== want_word.done_res ||
            out_word.rx_byte !== want_word.rx_byte ||
            out_word.ack_received !== want_word.ack_received) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch exp %b%b%b%b%b %h %b got %b%b%b%b%b %h %b",
                     want_word.scl_level, want_word.sda_drive_level, want_word.sda_released,
                     want_word.busy_res, want_word.done_res, want_word.rx_byte,
                     want_word.ack_received,
                     out_word.scl_level, out_word.sda_drive_level, out_word.sda_released,
                     out_word.busy_res, out_word.done_res, out_word.rx_byte,
                     out_word.ack_received);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_phase_len();
    test_zero_phase_len();
    test_each_command();
    test_long_phase();
    test_random_traffic();
    drain_results();
    // spare idle time after the drain catches stray result words
    repeat (4) @(negedge clk);
    if (fail_count == 0 && expected_pins.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Watchdog for a run that never finishes.
  initial begin
    #500000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
